### hw/rtl/lfss_pkg.sv
`default_nettype none

package lfss_pkg;

  localparam int unsigned ErrW    = 13;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned SteerW  = 8;
  localparam int unsigned DutyW   = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CfgIdxW-1:0] REG_DEADBAND      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STEER_GAIN    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_STEER_LIMIT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BASE_SPEED    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN_SPEED     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TARGET_PERIOD = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SPEED_GAIN    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_TURN_PENALTY  = 3'd7;

  localparam logic [11:0] RST_DEADBAND      = 12'd100;
  localparam logic [11:0] RST_STEER_GAIN    = 12'd225;
  localparam logic [6:0]  RST_STEER_LIMIT   = 7'd100;
  localparam logic [6:0]  RST_BASE_SPEED    = 7'd40;
  localparam logic [6:0]  RST_MIN_SPEED     = 7'd20;
  localparam logic [15:0] RST_TARGET_PERIOD = 16'd3500;
  localparam logic [9:0]  RST_SPEED_GAIN    = 10'd340;
  localparam logic [7:0]  RST_TURN_PENALTY  = 8'd26;

  // 51200 = 2048 * 25; the divide by 25 uses ceil(2^21 / 25), exact below 91180.
  localparam logic [15:0] SPEED_DIV    = 16'd51200;
  localparam logic [16:0] RECIP_25     = 17'd83887;
  localparam logic [15:0] STALL_PERIOD = 16'd500;
  localparam logic [6:0]  STALL_DUTY   = 7'd90;
  localparam logic [6:0]  DUTY_MAX     = 7'd100;

endpackage

`default_nettype wire

### hw/rtl/lfss_if.sv
`default_nettype none

interface lfss_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lfss_pkg::ErrW-1:0]       line_error;
  logic        [lfss_pkg::PeriodW-1:0]    encoder_period;
  modport source (output valid, output line_error, output encoder_period, input ready);
  modport sink   (input valid, input line_error, input encoder_period, output ready);
endinterface

interface lfss_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lfss_pkg::SteerW-1:0]     steer_cmd;
  logic        [lfss_pkg::DutyW-1:0]      drive_duty;
  modport source (output valid, output steer_cmd, output drive_duty, input ready);
  modport sink   (input valid, input steer_cmd, input drive_duty, output ready);
endinterface

interface lfss_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [lfss_pkg::CfgIdxW-1:0]           index;
  logic [lfss_pkg::CfgDatW-1:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/line_follow_steer_speed_law.sv
// Channel   Direction  Beat payload
// in_ch     sink       line_error (13b signed), encoder_period (16b)
// out_ch    source     steer_cmd (8b signed), drive_duty (7b)
// cfg_ch    sink       index (3b), data (16b), always ready
//
// Four register stages; one beat per cycle is sustained when
// out_ch is ready.
// The stages are the steering and feedback multipliers, the divide by 25
// reciprocal multiply, and the penalty and saturation stage into the output.
// A stall on out_ch only holds the stages that are full; empty stages keep
// filling. Synchronous reset empties the pipeline and loads register defaults.
`default_nettype none

module line_follow_steer_speed_law (
  input  wire logic     clk,
  input  wire logic     rst_n,
  lfss_in_if.sink       in_ch,
  lfss_out_if.source    out_ch,
  lfss_cfg_if.sink      cfg_ch
);

  logic [11:0] deadband_r;
  logic [11:0] steer_gain_r;
  logic [6:0]  steer_limit_r;
  logic [6:0]  base_speed_r;
  logic [6:0]  min_speed_r;
  logic [15:0] target_period_r;
  logic [9:0]  speed_gain_r;
  logic [7:0]  turn_penalty_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r      <= lfss_pkg::RST_DEADBAND;
      steer_gain_r    <= lfss_pkg::RST_STEER_GAIN;
      steer_limit_r   <= lfss_pkg::RST_STEER_LIMIT;
      base_speed_r    <= lfss_pkg::RST_BASE_SPEED;
      min_speed_r     <= lfss_pkg::RST_MIN_SPEED;
      target_period_r <= lfss_pkg::RST_TARGET_PERIOD;
      speed_gain_r    <= lfss_pkg::RST_SPEED_GAIN;
      turn_penalty_r  <= lfss_pkg::RST_TURN_PENALTY;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        lfss_pkg::REG_DEADBAND:      deadband_r      <= cfg_ch.data[11:0];
        lfss_pkg::REG_STEER_GAIN:    steer_gain_r    <= cfg_ch.data[11:0];
        lfss_pkg::REG_STEER_LIMIT:   steer_limit_r   <= cfg_ch.data[6:0];
        lfss_pkg::REG_BASE_SPEED:    base_speed_r    <= cfg_ch.data[6:0];
        lfss_pkg::REG_MIN_SPEED:     min_speed_r     <= cfg_ch.data[6:0];
        lfss_pkg::REG_TARGET_PERIOD: target_period_r <= cfg_ch.data[15:0];
        lfss_pkg::REG_SPEED_GAIN:    speed_gain_r    <= cfg_ch.data[9:0];
        lfss_pkg::REG_TURN_PENALTY:  turn_penalty_r  <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || out_ch.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 1: steering product, deadband test, period error, stall test.
  logic        [12:0] err_abs;
  logic signed [25:0] s1_prod_nxt;
  logic signed [16:0] s1_diff_nxt;
  logic signed [25:0] s1_prod_r;
  logic signed [16:0] s1_diff_r;
  logic               s1_en_r;
  logic               s1_stall_r;

  assign err_abs     = in_ch.line_error[12] ? 13'(-in_ch.line_error) : 13'(in_ch.line_error);
  assign s1_prod_nxt = 26'($signed({1'b0, steer_gain_r})) * 26'(in_ch.line_error);
  assign s1_diff_nxt = $signed({1'b0, target_period_r}) - $signed({1'b0, in_ch.encoder_period});

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_prod_r  <= s1_prod_nxt;
      s1_diff_r  <= s1_diff_nxt;
      s1_en_r    <= err_abs > {1'b0, deadband_r};
      s1_stall_r <= in_ch.encoder_period < lfss_pkg::STALL_PERIOD;
    end
  end

  // Stage 2: steering scale and clamp, feedback numerator.
  logic signed [25:0] sq_adj;
  logic signed [13:0] steer_q;
  logic signed [13:0] lim_s;
  logic signed [13:0] steer_c;
  logic        [22:0] base_term;
  logic signed [27:0] fb_prod;
  logic signed [27:0] s2_n_nxt;
  logic signed [7:0]  s2_steer_r;
  logic        [6:0]  s2_mag_r;
  logic signed [27:0] s2_n_r;
  logic               s2_stall_r;

  assign sq_adj  = s1_prod_r + (s1_prod_r[25] ? 26'sd4095 : 26'sd0);
  assign steer_q = sq_adj[25:12];
  assign lim_s   = $signed({7'd0, steer_limit_r});

  always_comb begin
    if (!s1_en_r) begin
      steer_c = '0;
    end else if (steer_q > lim_s) begin
      steer_c = lim_s;
    end else if (steer_q < -lim_s) begin
      steer_c = -lim_s;
    end else begin
      steer_c = steer_q;
    end
  end

  assign base_term = 23'(base_speed_r) * 23'(lfss_pkg::SPEED_DIV);
  assign fb_prod   = 28'($signed({1'b0, speed_gain_r})) * 28'(s1_diff_r);
  assign s2_n_nxt  = $signed({5'd0, base_term}) + fb_prod;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_steer_r <= steer_c[7:0];
      s2_mag_r   <= steer_c[13] ? 7'(-steer_c) : steer_c[6:0];
      s2_n_r     <= s2_n_nxt;
      s2_stall_r <= s1_stall_r;
    end
  end

  // Stage 3: divide the feedback numerator by 51200, turn penalty product.
  logic [27:0] n_abs;
  logic [32:0] recip_prod;
  logic [11:0] s3_q_r;
  logic        s3_neg_r;
  logic [14:0] s3_pen_r;
  logic signed [7:0] s3_steer_r;
  logic        s3_stall_r;

  assign n_abs      = s2_n_r[27] ? 28'(-s2_n_r) : 28'(s2_n_r);
  assign recip_prod = 33'(n_abs[26:11]) * 33'(lfss_pkg::RECIP_25);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_q_r     <= recip_prod[32:21];
      s3_neg_r   <= s2_n_r[27];
      s3_pen_r   <= 15'(turn_penalty_r) * 15'(s2_mag_r);
      s3_steer_r <= s2_steer_r;
      s3_stall_r <= s2_stall_r;
    end
  end

  // Stage 4: penalty, truncation, saturation and stall kick into the output.
  logic signed [12:0] d1;
  logic signed [21:0] pm;
  logic signed [21:0] pm_adj;
  logic signed [13:0] d2;
  logic        [6:0]  duty_nxt;
  logic signed [7:0]  out_steer_r;
  logic        [6:0]  out_duty_r;

  assign d1     = s3_neg_r ? -$signed({1'b0, s3_q_r}) : $signed({1'b0, s3_q_r});
  assign pm     = $signed({d1[12], d1, 8'd0}) - $signed({7'd0, s3_pen_r});
  assign pm_adj = pm + (pm[21] ? 22'sd255 : 22'sd0);
  assign d2     = pm_adj[21:8];

  always_comb begin
    if (s3_stall_r) begin
      duty_nxt = lfss_pkg::STALL_DUTY;
    end else if (d2 > $signed({7'd0, lfss_pkg::DUTY_MAX})) begin
      duty_nxt = lfss_pkg::DUTY_MAX;
    end else if (d2 < $signed({7'd0, min_speed_r})) begin
      duty_nxt = min_speed_r;
    end else begin
      duty_nxt = d2[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_steer_r <= s3_steer_r;
      out_duty_r  <= duty_nxt;
    end
  end

  assign out_ch.valid      = v4_r;
  assign out_ch.steer_cmd  = out_steer_r;
  assign out_ch.drive_duty = out_duty_r;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("Output valid right after reset.");

  a_stall_kick: assert property (@(posedge clk) disable iff (!rst_n)
    en4 && v3_r && s3_stall_r |=> out_ch.drive_duty == lfss_pkg::STALL_DUTY)
    else $error("Short encoder period did not give the stall kick duty.");

  a_steer_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.steer_cmd <= $signed({1'b0, steer_limit_r}))
                  && (out_ch.steer_cmd >= -$signed({1'b0, steer_limit_r})))
    else $error("Steering command beyond the steering limit.");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.drive_duty <= lfss_pkg::DUTY_MAX
                  || out_ch.drive_duty == min_speed_r)
    else $error("Drive duty outside its saturation range.");

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && en4 |=> v4_r)
    else $error("A beat was lost between the last two stages.");
`endif

endmodule

`default_nettype wire

### verif/steer_speed_check.sv
`timescale 1ns / 100ps

module steer_speed_check (
  input  logic clk,
  input  logic rst_n,
  lfss_in_if   in_ch,
  lfss_out_if  out_ch,
  lfss_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending_beats
);

  localparam longint SteerDiv    = 4096;
  localparam longint PenaltyDiv  = 256;
  localparam longint SpeedDiv    = lfss_pkg::SPEED_DIV;
  localparam longint DutyCeil    = lfss_pkg::DUTY_MAX;
  localparam longint StallPeriod = lfss_pkg::STALL_PERIOD;
  localparam longint StallDuty   = lfss_pkg::STALL_DUTY;

  typedef struct packed {
    logic signed [lfss_pkg::SteerW-1:0] steer;
    logic [lfss_pkg::DutyW-1:0]         duty;
  } drive_cmd_t;

  logic [11:0] deadband_q;
  logic [11:0] steer_gain_q;
  logic [6:0]  steer_limit_q;
  logic [6:0]  base_speed_q;
  logic [6:0]  min_speed_q;
  logic [15:0] target_period_q;
  logic [9:0]  speed_gain_q;
  logic [7:0]  turn_penalty_q;

  drive_cmd_t expected_cmds[$];

  function automatic drive_cmd_t steer_duty_law(
      input logic signed [lfss_pkg::ErrW-1:0] err_in,
      input logic [lfss_pkg::PeriodW-1:0] period_in);
    longint err, period, db, lim, gain, base, tgt, sgain, pen, duty_floor;
    longint steer, mag, duty;
    drive_cmd_t cmd;
    err = longint'(err_in);
    period = longint'(period_in);
    db = longint'(deadband_q);
    lim = longint'(steer_limit_q);
    gain = longint'(steer_gain_q);
    base = longint'(base_speed_q);
    tgt = longint'(target_period_q);
    sgain = longint'(speed_gain_q);
    pen = longint'(turn_penalty_q);
    duty_floor = longint'(min_speed_q);
    steer = 0;
    if (err > db) begin
      steer = gain * err / SteerDiv;
      if (steer > lim) steer = lim;
    end else if (err < -db) begin
      steer = gain * err / SteerDiv;
      if (steer < -lim) steer = -lim;
    end
    mag = (steer < 0) ? -steer : steer;
    // Both corrections truncate the running duty as a whole.
    duty = (base * SpeedDiv + sgain * (tgt - period)) / SpeedDiv;
    duty = (duty * PenaltyDiv - pen * mag) / PenaltyDiv;
    if (duty > DutyCeil) duty = DutyCeil;
    else if (duty < duty_floor) duty = duty_floor;
    if (period < StallPeriod) duty = StallDuty;
    cmd.steer = steer[lfss_pkg::SteerW-1:0];
    cmd.duty = duty[lfss_pkg::DutyW-1:0];
    return cmd;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t check: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst_n) begin
      deadband_q = lfss_pkg::RST_DEADBAND;
      steer_gain_q = lfss_pkg::RST_STEER_GAIN;
      steer_limit_q = lfss_pkg::RST_STEER_LIMIT;
      base_speed_q = lfss_pkg::RST_BASE_SPEED;
      min_speed_q = lfss_pkg::RST_MIN_SPEED;
      target_period_q = lfss_pkg::RST_TARGET_PERIOD;
      speed_gain_q = lfss_pkg::RST_SPEED_GAIN;
      turn_penalty_q = lfss_pkg::RST_TURN_PENALTY;
      expected_cmds.delete();
      fail_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          lfss_pkg::REG_DEADBAND:      deadband_q = cfg_ch.data[11:0];
          lfss_pkg::REG_STEER_GAIN:    steer_gain_q = cfg_ch.data[11:0];
          lfss_pkg::REG_STEER_LIMIT:   steer_limit_q = cfg_ch.data[6:0];
          lfss_pkg::REG_BASE_SPEED:    base_speed_q = cfg_ch.data[6:0];
          lfss_pkg::REG_MIN_SPEED:     min_speed_q = cfg_ch.data[6:0];
          lfss_pkg::REG_TARGET_PERIOD: target_period_q = cfg_ch.data[15:0];
          lfss_pkg::REG_SPEED_GAIN:    speed_gain_q = cfg_ch.data[9:0];
          lfss_pkg::REG_TURN_PENALTY:  turn_penalty_q = cfg_ch.data[7:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_cmds.push_back(steer_duty_law(in_ch.line_error, in_ch.encoder_period));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected beat steer %0d duty %0d",
                                    out_ch.steer_cmd, out_ch.drive_duty));
        end else begin
          want = expected_cmds.pop_front();
          if (out_ch.steer_cmd !== want.steer) begin
            report_mismatch($sformatf("steer_cmd %0d, expected %0d",
                                      out_ch.steer_cmd, want.steer));
          end
          if (out_ch.drive_duty !== want.duty) begin
            report_mismatch($sformatf("drive_duty %0d, expected %0d",
                                      out_ch.drive_duty, want.duty));
          end
        end
      end
    end
    pending_beats = expected_cmds.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

  typedef enum int {SetReset, SetMax, SetZero, SetRandom} setting_t;

  logic        clk;
  logic        rst_n;
  int unsigned send_idle;
  int unsigned recv_idle;
  int          fail_count;
  int          pending_beats;

  logic [15:0] reg_vals [8];
  int unsigned reg_width [8] = '{12, 12, 7, 7, 7, 16, 10, 8};
  setting_t    first_kind [3] = '{SetMax, SetZero, SetReset};

  int directed_err [20] = '{0, 100, -100, 101, -101, 4095, -4095, -4096, 4095, -4096,
                            1000, -1000, 2048, -2048, 1, -1, 300, -300, 4095, 0};
  int directed_period [20] = '{3500, 3500, 3500, 3500, 3500, 3500, 3500, 3500, 65535, 0,
                               499, 500, 0, 65535, 10000, 1000, 3600, 3400, 501, 65535};

  lfss_in_if  in_ch ();
  lfss_out_if out_ch ();
  lfss_cfg_if cfg_ch ();

  line_follow_steer_speed_law dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  steer_speed_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic send_item(input int err, input int period);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.line_error <= err[lfss_pkg::ErrW-1:0];
    in_ch.encoder_period <= period[lfss_pkg::PeriodW-1:0];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic random_item(output int err, output int period);
    int unsigned pick;
    int db;
    int tgt;
    db = int'(reg_vals[lfss_pkg::REG_DEADBAND]);
    tgt = int'(reg_vals[lfss_pkg::REG_TARGET_PERIOD]);
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      // Hug the deadband edge from either side.
      err = db + int'($urandom_range(0, 4)) - 2;
      if (err > 4095) err = 4095;
      if ($urandom_range(0, 1) == 1) err = -err;
    end else if (pick < 7) begin
      err = int'($urandom_range(0, 8191)) - 4096;
    end else if (pick == 7) begin
      case ($urandom_range(0, 2))
        0: err = -4096;
        1: err = 4095;
        default: err = -4095;
      endcase
    end else begin
      err = int'($urandom_range(0, 1200)) - 600;
    end
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      period = int'($urandom_range(0, 520));
    end else if (pick < 7) begin
      period = tgt + int'($urandom_range(0, 6000)) - 3000;
      if (period < 0) period = 0;
      if (period > 65535) period = 65535;
    end else if (pick < 9) begin
      period = int'($urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 3))
        0: period = 0;
        1: period = 65535;
        2: period = 499;
        default: period = 500;
      endcase
    end
  endtask

  task automatic choose_setting(input setting_t kind);
    logic [15:0] mask;
    logic [15:0] junk;
    case (kind)
      SetReset: begin
        reg_vals[lfss_pkg::REG_DEADBAND] = 16'(lfss_pkg::RST_DEADBAND);
        reg_vals[lfss_pkg::REG_STEER_GAIN] = 16'(lfss_pkg::RST_STEER_GAIN);
        reg_vals[lfss_pkg::REG_STEER_LIMIT] = 16'(lfss_pkg::RST_STEER_LIMIT);
        reg_vals[lfss_pkg::REG_BASE_SPEED] = 16'(lfss_pkg::RST_BASE_SPEED);
        reg_vals[lfss_pkg::REG_MIN_SPEED] = 16'(lfss_pkg::RST_MIN_SPEED);
        reg_vals[lfss_pkg::REG_TARGET_PERIOD] = lfss_pkg::RST_TARGET_PERIOD;
        reg_vals[lfss_pkg::REG_SPEED_GAIN] = 16'(lfss_pkg::RST_SPEED_GAIN);
        reg_vals[lfss_pkg::REG_TURN_PENALTY] = 16'(lfss_pkg::RST_TURN_PENALTY);
      end
      SetMax: begin
        foreach (reg_vals[i]) reg_vals[i] = 16'hFFFF >> (16 - reg_width[i]);
      end
      SetZero: begin
        foreach (reg_vals[i]) reg_vals[i] = '0;
      end
      default: begin
        reg_vals[lfss_pkg::REG_DEADBAND] = 16'($urandom_range(0, 400));
        reg_vals[lfss_pkg::REG_STEER_GAIN] = 16'($urandom_range(0, 4095));
        reg_vals[lfss_pkg::REG_STEER_LIMIT] = 16'($urandom_range(0, 127));
        reg_vals[lfss_pkg::REG_BASE_SPEED] = 16'($urandom_range(0, 100));
        reg_vals[lfss_pkg::REG_MIN_SPEED] = ($urandom_range(0, 3) == 0)
                                            ? 16'($urandom_range(101, 127))
                                            : 16'($urandom_range(0, 60));
        reg_vals[lfss_pkg::REG_TARGET_PERIOD] = 16'($urandom_range(0, 65535));
        reg_vals[lfss_pkg::REG_SPEED_GAIN] = 16'($urandom_range(0, 1023));
        reg_vals[lfss_pkg::REG_TURN_PENALTY] = 16'($urandom_range(0, 255));
      end
    endcase
    // Bits above each register's width carry noise and must be dropped.
    cfg_ch.valid <= 1'b1;
    foreach (reg_vals[i]) begin
      mask = 16'hFFFF >> (16 - reg_width[i]);
      junk = 16'($urandom);
      cfg_ch.index <= lfss_pkg::CfgIdxW'(i);
      cfg_ch.data <= reg_vals[i] | (junk & ~mask);
      do @(posedge clk); while (!cfg_ch.ready);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int err;
    int period;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.line_error = '0;
    in_ch.encoder_period = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    send_idle = 38;
    recv_idle = 62;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_err[k]) send_item(directed_err[k], directed_period[k]);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 38 : (ph == 1) ? 62 : 0;
      recv_idle = (ph == 0) ? 62 : (ph == 1) ? 38 : 0;
      for (int k = 0; k < 2; k++) begin
        in_ch.valid <= 1'b0;
        while (pending_beats != 0) @(negedge clk);
        choose_setting((k == 0) ? first_kind[ph] : SetRandom);
        repeat (280) begin
          random_item(err, period);
          send_item(err, period);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
